>>> rtl/core/field_point_camera_projection_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the field point camera projection block
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef FIELD_POINT_CAMERA_PROJECTION_ASSERT_SVH
`define FIELD_POINT_CAMERA_PROJECTION_ASSERT_SVH

// Same-cycle implication
`define FPCP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fpcp: same-cycle check failed");

// Next-cycle implication
`define FPCP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fpcp: next-cycle check failed");

`endif

>>> rtl/core/fpcp_pkg.sv
// ----------------------------------------------------------------------------
// fpcp_pkg
// Shared types, widths and constants of the field point camera projection.
// ----------------------------------------------------------------------------
`default_nettype none

package fpcp_pkg;

   // Image size in pixels
   localparam int IMAGE_W = 640;
   localparam int IMAGE_H = 480;

   // Register indexes of the configuration port
   localparam logic [3:0] REG_ROBOT_X       = 4'd0;
   localparam logic [3:0] REG_ROBOT_Y       = 4'd1;
   localparam logic [3:0] REG_ROBOT_HEADING = 4'd2;
   localparam logic [3:0] REG_HEAD_YAW      = 4'd3;
   localparam logic [3:0] REG_HEAD_PITCH    = 4'd4;
   localparam logic [3:0] REG_CAM_HEIGHT    = 4'd5;
   localparam logic [3:0] REG_CAM_PITCH_OFS = 4'd6;
   localparam logic [3:0] REG_FOCAL         = 4'd7;

   // Divider operand widths: |y2| < 2^23, focal length has 12 bits
   localparam int DEN_W = 24;
   localparam int NUM_W = DEN_W + 12;

   // Sine and cosine of the two rotation angles, Q1.15
   typedef struct packed {
      logic signed [15:0] cos_yaw;
      logic signed [15:0] sin_yaw;
      logic signed [15:0] cos_pitch;
      logic signed [15:0] sin_pitch;
   } trig_type;

   // Pose and optics registers used by the transform pipeline
   typedef struct packed {
      logic signed [11:0] robot_x;
      logic signed [11:0] robot_y;
      logic [7:0]         camera_height;
      logic [11:0]        focal_px;
   } pose_type;

   // Flags that travel alongside the quotients
   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic depth_zero;
   } div_side_type;

   // Partial remainder and numerator/quotient shift word of one lane
   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [NUM_W-1:0] num;
   } div_state_type;

   // One restoring division step: shift in a numerator bit, subtract if it fits
   function automatic div_state_type div_step(div_state_type s, logic [DEN_W-1:0] den);
      logic [DEN_W:0] sh;
      div_state_type  r;
      sh = {s.rem, s.num[NUM_W-1]};
      if (sh >= {1'b0, den}) begin
         r.rem = DEN_W'(sh - {1'b0, den});
         r.num = {s.num[NUM_W-2:0], 1'b1};
      end else begin
         r.rem = sh[DEN_W-1:0];
         r.num = {s.num[NUM_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/fpcp_trig.sv
// ----------------------------------------------------------------------------
// fpcp_trig
// Sequential sine/cosine unit. Evaluates cos and sin of yaw and pitch with a
// quarter-wave odd Taylor series (Horner, Q2.30) on one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module fpcp_trig
   import fpcp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [17:0] yaw,
   input  wire logic signed [17:0] pitch,
   output logic                    ready,
   output trig_type                trig
);

   localparam logic signed [18:0] FULL_TURN = 19'sd46080;
   localparam logic signed [18:0] QUARTER   = 19'sd11520;
   localparam logic [31:0]        RAD_Q30   = 32'd146409;
   localparam logic [30:0]        ONE_Q30   = 31'h4000_0000;
   localparam logic [63:0]        HALF_Q30  = 64'd536870912;
   localparam longint unsigned    TWO_34    = 64'd17179869184;
   localparam logic [31:0]        RECIP_0   = 32'(TWO_34 / 110);
   localparam logic [31:0]        RECIP_1   = 32'(TWO_34 / 72);
   localparam logic [31:0]        RECIP_2   = 32'(TWO_34 / 42);
   localparam logic [31:0]        RECIP_3   = 32'(TWO_34 / 20);
   localparam logic [31:0]        RECIP_4   = 32'(TWO_34 / 6);

   // Sequencer states
   localparam logic [3:0] S_LOAD = 4'd0;
   localparam logic [3:0] S_WRAP = 4'd1;
   localparam logic [3:0] S_M1   = 4'd2;
   localparam logic [3:0] S_U1   = 4'd3;
   localparam logic [3:0] S_M2   = 4'd4;
   localparam logic [3:0] S_U2   = 4'd5;
   localparam logic [3:0] S_M3   = 4'd6;
   localparam logic [3:0] S_U3   = 4'd7;
   localparam logic [3:0] S_M4   = 4'd8;
   localparam logic [3:0] S_U4   = 4'd9;
   localparam logic [3:0] S_M5   = 4'd10;
   localparam logic [3:0] S_U5   = 4'd11;
   localparam logic [3:0] S_DONE = 4'd12;

   logic [3:0]         state_ff, state_in;
   logic [1:0]         ang_ff, ang_in;
   logic [2:0]         i_ff, i_in;
   logic signed [18:0] m_ff, m_in;
   logic [13:0]        f_ff, f_in;
   logic               neg_ff, neg_in;
   logic [30:0]        x_ff, x_in;
   logic [31:0]        x2_ff, x2_in;
   logic [30:0]        t_ff, t_in;
   logic [31:0]        p_ff, p_in;
   logic [63:0]        prod_ff, prod_in;
   trig_type           trig_ff, trig_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] rnd;
   logic [15:0] mu;
   logic [15:0] f_raw;
   logic [1:0]  quad;
   logic [29:0] q0;
   logic [36:0] rem;
   logic [29:0] qv;
   logic [6:0]  dv;
   logic [31:0] recip;
   logic [32:0] sq;
   logic [17:0] sq15;
   logic signed [15:0] mag, res;

   // Series divisor and its scaled reciprocal per Horner step
   always_comb begin
      case (i_ff)
         3'd0:    begin dv = 7'd110; recip = RECIP_0; end
         3'd1:    begin dv = 7'd72;  recip = RECIP_1; end
         3'd2:    begin dv = 7'd42;  recip = RECIP_2; end
         3'd3:    begin dv = 7'd20;  recip = RECIP_3; end
         default: begin dv = 7'd6;   recip = RECIP_4; end
      endcase
   end

   // Quadrant split of the wrapped angle
   always_comb begin
      mu = m_ff[15:0];
      if (mu >= 16'd34560) begin
         quad  = 2'd3;
         f_raw = mu - 16'd34560;
      end else if (mu >= 16'd23040) begin
         quad  = 2'd2;
         f_raw = mu - 16'd23040;
      end else if (mu >= 16'd11520) begin
         quad  = 2'd1;
         f_raw = mu - 16'd11520;
      end else begin
         quad  = 2'd0;
         f_raw = mu;
      end
   end

   // Shared multiplier operands
   always_comb begin
      case (state_ff)
         S_M1:    begin mul_a = 32'(f_ff);  mul_b = RAD_Q30;     end
         S_M2:    begin mul_a = 32'(x_ff);  mul_b = 32'(x_ff);   end
         S_M3:    begin mul_a = x2_ff;      mul_b = 32'(t_ff);   end
         S_M4:    begin mul_a = p_ff;       mul_b = recip;       end
         default: begin mul_a = 32'(x_ff);  mul_b = 32'(t_ff);   end
      endcase
      prod_in = {32'd0, mul_a} * {32'd0, mul_b};
   end

   // Rounding, reciprocal correction and final scaling
   always_comb begin
      rnd  = prod_ff + HALF_Q30;
      q0   = prod_ff[63:34];
      rem  = {5'd0, p_ff} - (37'(q0) * 37'(dv));
      qv   = (rem >= 37'(dv)) ? q0 + 30'd1 : q0;
      sq   = {1'b0, rnd[61:30]} + 33'd16384;
      sq15 = sq[32:15];
      mag  = (sq15 > 18'd32767) ? 16'sd32767 : $signed(sq15[15:0]);
      res  = neg_ff ? -mag : mag;
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      ang_in   = ang_ff;
      i_in     = i_ff;
      m_in     = m_ff;
      f_in     = f_ff;
      neg_in   = neg_ff;
      x_in     = x_ff;
      x2_in    = x2_ff;
      t_in     = t_ff;
      p_in     = p_ff;
      trig_in  = trig_ff;
      unique case (state_ff)
         S_LOAD: begin
            case (ang_ff)
               2'd0:    m_in = 19'(yaw) + QUARTER;
               2'd1:    m_in = 19'(yaw);
               2'd2:    m_in = 19'(pitch) + QUARTER;
               default: m_in = 19'(pitch);
            endcase
            state_in = S_WRAP;
         end
         S_WRAP: begin
            if (m_ff < 0) begin
               m_in = m_ff + FULL_TURN;
            end else if (m_ff >= FULL_TURN) begin
               m_in = m_ff - FULL_TURN;
            end else begin
               f_in     = quad[0] ? 14'(16'd11520 - f_raw) : 14'(f_raw);
               neg_in   = quad[1];
               state_in = S_M1;
            end
         end
         S_M1: state_in = S_U1;
         S_U1: begin
            x_in     = prod_ff[30:0];
            state_in = S_M2;
         end
         S_M2: state_in = S_U2;
         S_U2: begin
            x2_in    = rnd[61:30];
            t_in     = ONE_Q30;
            i_in     = 3'd0;
            state_in = S_M3;
         end
         S_M3: state_in = S_U3;
         S_U3: begin
            p_in     = rnd[61:30];
            state_in = S_M4;
         end
         S_M4: state_in = S_U4;
         S_U4: begin
            t_in     = ONE_Q30 - 31'(qv);
            i_in     = i_ff + 3'd1;
            state_in = (i_ff == 3'd4) ? S_M5 : S_M3;
         end
         S_M5: state_in = S_U5;
         S_U5: begin
            case (ang_ff)
               2'd0:    trig_in.cos_yaw   = res;
               2'd1:    trig_in.sin_yaw   = res;
               2'd2:    trig_in.cos_pitch = res;
               default: trig_in.sin_pitch = res;
            endcase
            ang_in   = ang_ff + 2'd1;
            state_in = (ang_ff == 2'd3) ? S_DONE : S_LOAD;
         end
         S_DONE: state_in = S_DONE;
         default: state_in = S_LOAD;
      endcase
      // Restart on any new pose
      if (start) begin
         state_in = S_LOAD;
         ang_in   = 2'd0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         ang_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         ang_ff   <= ang_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      m_ff    <= m_in;
      f_ff    <= f_in;
      neg_ff  <= neg_in;
      x_ff    <= x_in;
      x2_ff   <= x2_in;
      t_ff    <= t_in;
      p_ff    <= p_in;
      prod_ff <= prod_in;
      trig_ff <= trig_in;
   end

   assign ready = (state_ff == S_DONE);
   assign trig  = trig_ff;

endmodule

`default_nettype wire

>>> rtl/core/fpcp_xform.sv
// ----------------------------------------------------------------------------
// fpcp_xform
// Seven-stage pipeline: translate, yaw rotate, pitch rotate, then form
// magnitudes and scaled numerators for the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module fpcp_xform
   import fpcp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic signed [11:0] in_point_x,
   input  wire logic signed [11:0] in_point_y,
   input  wire logic signed [11:0] in_point_z,
   input  wire pose_type           pose,
   input  wire trig_type           trig,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic [NUM_W-1:0]        out_num_x,
   output logic [NUM_W-1:0]        out_num_y,
   output logic [DEN_W-1:0]        out_den,
   output div_side_type            out_side
);

   localparam int STAGES = 7;

   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] adv;

   // Stage 0: translation
   logic signed [12:0] tx_ff, ty_ff, tz_ff, tx_in, ty_in, tz_in;
   // Stage 1: yaw products
   logic signed [28:0] pa_ff, pb_ff, pc_ff, pd_ff, pa_in, pb_in, pc_in, pd_in;
   logic signed [12:0] tz1_ff;
   // Stage 2: yaw sums
   logic signed [23:0] x1_ff, y1_ff, x1_in, y1_in;
   logic signed [20:0] z1_ff, z1_in;
   // Stage 3: pitch products
   logic signed [39:0] pe_ff, pf_ff, pg_ff, ph_ff, pe_in, pf_in, pg_in, ph_in;
   logic signed [23:0] x1b_ff;
   // Stage 4: pitch sums
   logic signed [23:0] y2_ff, z2_ff, y2_in, z2_in;
   logic signed [23:0] x1c_ff;
   // Stage 5: magnitudes and signs
   logic [DEN_W-1:0]   ax_ff, ay_ff, az_ff, ax_in, ay_in, az_in;
   div_side_type       sd5_ff, sd5_in;
   // Stage 6: numerators
   logic [NUM_W-1:0]   nx_ff, ny_ff;
   logic [DEN_W-1:0]   az6_ff;
   div_side_type       sd6_ff;

   logic signed [29:0] sx, sy;
   logic signed [40:0] sy2, sz2;

   // Stall chain: a stage moves when it is empty or the next one moves
   always_comb begin
      adv[STAGES-1] = !v_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // Stage logic
   always_comb begin
      tx_in = 13'(in_point_x) - 13'(pose.robot_x);
      ty_in = 13'(in_point_y) - 13'(pose.robot_y);
      tz_in = 13'(in_point_z) - $signed({5'd0, pose.camera_height});

      pa_in = 29'(trig.cos_yaw) * 29'(tx_ff);
      pb_in = 29'(trig.sin_yaw) * 29'(ty_ff);
      pc_in = 29'(trig.sin_yaw) * 29'(tx_ff);
      pd_in = 29'(trig.cos_yaw) * 29'(ty_ff);

      sx    = 30'(pa_ff) - 30'(pb_ff);
      sy    = 30'(pc_ff) + 30'(pd_ff);
      x1_in = 24'((sx + 30'sd64) >>> 7);
      y1_in = 24'((sy + 30'sd64) >>> 7);
      z1_in = $signed({tz1_ff, 8'd0});

      pe_in = 40'(trig.cos_pitch) * 40'(y1_ff);
      pf_in = 40'(trig.sin_pitch) * 40'(z1_ff);
      pg_in = 40'(trig.sin_pitch) * 40'(y1_ff);
      ph_in = 40'(trig.cos_pitch) * 40'(z1_ff);

      sy2   = 41'(pe_ff) - 41'(pf_ff);
      sz2   = 41'(pg_ff) + 41'(ph_ff);
      y2_in = 24'((sy2 + 41'sd16384) >>> 15);
      z2_in = 24'((sz2 + 41'sd16384) >>> 15);

      ax_in = DEN_W'(x1c_ff[23] ? -x1c_ff : x1c_ff);
      ay_in = DEN_W'(y2_ff[23] ? -y2_ff : y2_ff);
      sd5_in.depth_zero = (z2_ff == '0);
      sd5_in.neg_x      = x1c_ff[23] ^ z2_ff[23];
      sd5_in.neg_y      = y2_ff[23] ^ z2_ff[23];
      // Divide by one on zero depth; the quotient is replaced later
      if (z2_ff == '0) begin
         az_in = DEN_W'(1);
      end else begin
         az_in = DEN_W'(z2_ff[23] ? -z2_ff : z2_ff);
      end
   end

   // Pipeline registers, advanced per stage
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         tx_ff <= tx_in;
         ty_ff <= ty_in;
         tz_ff <= tz_in;
      end
      if (adv[1]) begin
         pa_ff  <= pa_in;
         pb_ff  <= pb_in;
         pc_ff  <= pc_in;
         pd_ff  <= pd_in;
         tz1_ff <= tz_ff;
      end
      if (adv[2]) begin
         x1_ff <= x1_in;
         y1_ff <= y1_in;
         z1_ff <= z1_in;
      end
      if (adv[3]) begin
         pe_ff  <= pe_in;
         pf_ff  <= pf_in;
         pg_ff  <= pg_in;
         ph_ff  <= ph_in;
         x1b_ff <= x1_ff;
      end
      if (adv[4]) begin
         y2_ff  <= y2_in;
         z2_ff  <= z2_in;
         x1c_ff <= x1b_ff;
      end
      if (adv[5]) begin
         ax_ff  <= ax_in;
         ay_ff  <= ay_in;
         az_ff  <= az_in;
         sd5_ff <= sd5_in;
      end
      if (adv[6]) begin
         nx_ff  <= NUM_W'(ax_ff) * NUM_W'(pose.focal_px);
         ny_ff  <= NUM_W'(ay_ff) * NUM_W'(pose.focal_px);
         az6_ff <= az_ff;
         sd6_ff <= sd5_ff;
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[STAGES-1];
   assign out_num_x = nx_ff;
   assign out_num_y = ny_ff;
   assign out_den   = az6_ff;
   assign out_side  = sd6_ff;

endmodule

`default_nettype wire

>>> rtl/core/fpcp_div.sv
// ----------------------------------------------------------------------------
// fpcp_div
// Pipelined restoring divider, two lanes over one shared divisor. Each stage
// resolves a fixed group of quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module fpcp_div
   import fpcp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire logic [NUM_W-1:0] in_num_x,
   input  wire logic [NUM_W-1:0] in_num_y,
   input  wire logic [DEN_W-1:0] in_den,
   input  wire div_side_type in_side,
   output logic              out_valid,
   input  wire logic         out_ready,
   output logic [NUM_W-1:0]  out_quo_x,
   output logic [NUM_W-1:0]  out_quo_y,
   output div_side_type      out_side
);

   localparam int STEPS  = 6;
   localparam int STAGES = NUM_W / STEPS;

   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] adv;

   div_state_type    lx_ff [STAGES];
   div_state_type    ly_ff [STAGES];
   logic [DEN_W-1:0] den_ff [STAGES];
   div_side_type     side_ff [STAGES];
   div_state_type    lx_in [STAGES];
   div_state_type    ly_in [STAGES];

   // Stall chain
   always_comb begin
      adv[STAGES-1] = !v_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // Resolve a group of quotient bits in each stage
   always_comb begin
      for (int k = 0; k < STAGES; k++) begin
         if (k == 0) begin
            lx_in[k] = '{rem: '0, num: in_num_x};
            ly_in[k] = '{rem: '0, num: in_num_y};
            for (int s = 0; s < STEPS; s++) begin
               lx_in[k] = div_step(lx_in[k], in_den);
               ly_in[k] = div_step(ly_in[k], in_den);
            end
         end else begin
            lx_in[k] = lx_ff[k-1];
            ly_in[k] = ly_ff[k-1];
            for (int s = 0; s < STEPS; s++) begin
               lx_in[k] = div_step(lx_in[k], den_ff[k-1]);
               ly_in[k] = div_step(ly_in[k], den_ff[k-1]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         lx_ff[0]   <= lx_in[0];
         ly_ff[0]   <= ly_in[0];
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (adv[k]) begin
            lx_ff[k]   <= lx_in[k];
            ly_ff[k]   <= ly_in[k];
            den_ff[k]  <= den_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[STAGES-1];
   assign out_quo_x = lx_ff[STAGES-1].num;
   assign out_quo_y = ly_ff[STAGES-1].num;
   assign out_side  = side_ff[STAGES-1];

endmodule

`default_nettype wire

>>> rtl/core/field_point_camera_projection.sv
// Pipeline: a req word passes 7 transform stages, 6 divider stages and 1 output
//   register before rsp_valid rises.
// Throughput: one point per cycle between stalls; the 36-bit divider resolves 6 bits a stage.
// Reset and every configuration write restart the sine/cosine sequencer, which
//   runs on one shared multiplier; req_ready stays low until it finishes. Reset
//   clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// field_point_camera_projection
// Projects a field point into camera pixels: translate, yaw and pitch
// rotation, pinhole divide, centre offset, saturation and image bounds test.
// ----------------------------------------------------------------------------
`default_nettype none

module field_point_camera_projection
   import fpcp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [3:0]         csr_index,
   input  wire logic [16:0]        csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [11:0] req_point_x,
   input  wire logic signed [11:0] req_point_y,
   input  wire logic signed [11:0] req_point_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_pixel_x,
   output logic signed [15:0]      rsp_pixel_y,
   output logic                    rsp_in_image,
   output logic                    rsp_depth_zero
);

`include "field_point_camera_projection_assert.svh"

   localparam logic signed [15:0] PX_ERR = 16'(IMAGE_W / 2 - 1);
   localparam logic signed [15:0] PY_ERR = 16'(IMAGE_H / 2 - 1);

   // Configuration registers
   logic signed [11:0] robot_x_ff, robot_y_ff;
   logic signed [16:0] heading_ff, head_yaw_ff, head_pitch_ff, pitch_ofs_ff;
   logic [7:0]         cam_height_ff;
   logic [11:0]        focal_ff;
   logic               csr_fire;

   logic signed [17:0] yaw_sum, pitch_sum;
   logic               trig_ready;
   trig_type           trig;
   pose_type           pose;

   logic               xf_in_ready, xf_out_valid, div_in_ready;
   logic [NUM_W-1:0]   xf_num_x, xf_num_y;
   logic [DEN_W-1:0]   xf_den;
   div_side_type       xf_side;

   logic               div_out_valid, out_adv;
   logic [NUM_W-1:0]   quo_x, quo_y;
   div_side_type       div_side;

   logic               rsp_valid_ff;
   logic signed [15:0] rsp_pixel_x_ff, rsp_pixel_y_ff, pix_x_in, pix_y_in;
   logic               rsp_in_image_ff, rsp_depth_zero_ff, in_image_in;

   // Sign, error value, centre offset and clamp of one quotient
   function automatic logic signed [15:0] place(logic [NUM_W-1:0] quo, logic neg,
                                                logic dz, int size);
      logic signed [NUM_W+1:0] p;
      logic signed [NUM_W+1:0] v;
      p = $signed({2'b00, quo});
      if (neg) begin
         p = -p;
      end
      if (dz) begin
         p = -(NUM_W+2)'(1);
      end
      v = p + (NUM_W+2)'(size / 2);
      if ((size % 2 == 1) && (v < 0)) begin
         v = v + (NUM_W+2)'(1);
      end
      if (v > (NUM_W+2)'(32767)) begin
         return 16'sh7fff;
      end else if (v < -(NUM_W+2)'(32768)) begin
         return 16'sh8000;
      end
      return 16'(v);
   endfunction

   // Register writes; indexes past the list are dropped
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         robot_x_ff    <= '0;
         robot_y_ff    <= '0;
         heading_ff    <= '0;
         head_yaw_ff   <= '0;
         head_pitch_ff <= '0;
         cam_height_ff <= '0;
         pitch_ofs_ff  <= '0;
         focal_ff      <= 12'd1;
      end else if (csr_fire) begin
         unique case (csr_index)
            REG_ROBOT_X:       robot_x_ff    <= csr_wdata[11:0];
            REG_ROBOT_Y:       robot_y_ff    <= csr_wdata[11:0];
            REG_ROBOT_HEADING: heading_ff    <= csr_wdata;
            REG_HEAD_YAW:      head_yaw_ff   <= csr_wdata;
            REG_HEAD_PITCH:    head_pitch_ff <= csr_wdata;
            REG_CAM_HEIGHT:    cam_height_ff <= csr_wdata[7:0];
            REG_CAM_PITCH_OFS: pitch_ofs_ff  <= csr_wdata;
            REG_FOCAL:         focal_ff      <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // Recompute sine and cosine of the combined angles
   assign yaw_sum   = 18'(head_yaw_ff) + 18'(heading_ff);
   assign pitch_sum = 18'(head_pitch_ff) + 18'(pitch_ofs_ff);

   fpcp_trig u_trig (
      .clock (clock),
      .reset (reset),
      .start (csr_fire),
      .yaw   (yaw_sum),
      .pitch (pitch_sum),
      .ready (trig_ready),
      .trig  (trig)
   );

   assign pose.robot_x       = robot_x_ff;
   assign pose.robot_y       = robot_y_ff;
   assign pose.camera_height = cam_height_ff;
   assign pose.focal_px      = focal_ff;

   // Hold off req words until the angles are ready
   assign req_ready = xf_in_ready && trig_ready;

   fpcp_xform u_xform (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid && trig_ready),
      .in_ready   (xf_in_ready),
      .in_point_x (req_point_x),
      .in_point_y (req_point_y),
      .in_point_z (req_point_z),
      .pose       (pose),
      .trig       (trig),
      .out_valid  (xf_out_valid),
      .out_ready  (div_in_ready),
      .out_num_x  (xf_num_x),
      .out_num_y  (xf_num_y),
      .out_den    (xf_den),
      .out_side   (xf_side)
   );

   fpcp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (xf_out_valid),
      .in_ready  (div_in_ready),
      .in_num_x  (xf_num_x),
      .in_num_y  (xf_num_y),
      .in_den    (xf_den),
      .in_side   (xf_side),
      .out_valid (div_out_valid),
      .out_ready (out_adv),
      .out_quo_x (quo_x),
      .out_quo_y (quo_y),
      .out_side  (div_side)
   );

   // Output stage: place pixels and test bounds
   assign out_adv = !rsp_valid_ff || rsp_ready;

   always_comb begin
      pix_x_in    = place(quo_x, div_side.neg_x, div_side.depth_zero, IMAGE_W);
      pix_y_in    = place(quo_y, div_side.neg_y, div_side.depth_zero, IMAGE_H);
      in_image_in = !pix_x_in[15] && (pix_x_in <= $signed(16'(IMAGE_W))) &&
                    !pix_y_in[15] && (pix_y_in <= $signed(16'(IMAGE_H)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         rsp_pixel_x_ff    <= pix_x_in;
         rsp_pixel_y_ff    <= pix_y_in;
         rsp_in_image_ff   <= in_image_in;
         rsp_depth_zero_ff <= div_side.depth_zero;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_x    = rsp_pixel_x_ff;
   assign rsp_pixel_y    = rsp_pixel_y_ff;
   assign rsp_in_image   = rsp_in_image_ff;
   assign rsp_depth_zero = rsp_depth_zero_ff;

   // Checks
   `FPCP_ASSERT_NOW(a_dz_value, rsp_valid_ff && rsp_depth_zero_ff,
      rsp_pixel_x_ff == PX_ERR && rsp_pixel_y_ff == PY_ERR)
   `FPCP_ASSERT_NOW(a_inside_nonneg, rsp_valid_ff && rsp_in_image_ff,
      !rsp_pixel_x_ff[15] && !rsp_pixel_y_ff[15])
   `FPCP_ASSERT_NEXT(a_cfg_recompute, csr_fire, !trig_ready && !req_ready)

endmodule

`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for field_point_camera_projection. A bit-exact predictor
// of the translate, yaw/pitch rotation, pinhole divide, centre offset and
// bounds test runs alongside the block. Directed points come first, then
// random points under several pose and optics settings, with random gaps on
// the req side and random stalls on the rsp side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import fpcp_pkg::*;

   localparam int        IDLE_LIMIT = 5000;
   localparam longint unsigned ONE_Q30 = 64'd1 << 30;
   localparam longint    FULL_TURN = 46080;
   localparam longint    QUARTER   = 11520;

   typedef struct packed {
      logic signed [15:0] pixel_x;
      logic signed [15:0] pixel_y;
      logic               in_image;
      logic               depth_zero;
   } pixel_type;

   typedef struct {
      logic signed [11:0] x;
      logic signed [11:0] y;
      logic signed [11:0] z;
      bit                 known;
      pixel_type          pix;
   } point_row_type;

   logic               clock;
   logic               reset;
   logic               csr_valid;
   logic               csr_ready;
   logic [3:0]         csr_index;
   logic [16:0]        csr_wdata;
   logic               req_valid;
   logic               req_ready;
   logic signed [11:0] req_point_x;
   logic signed [11:0] req_point_y;
   logic signed [11:0] req_point_z;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_pixel_x;
   logic signed [15:0] rsp_pixel_y;
   logic               rsp_in_image;
   logic               rsp_depth_zero;

   pixel_type          pending_pixels[$];
   longint             pose_regs[8];
   int                 errors;
   int                 idle_cycles;
   bit                 no_gaps;
   bit                 rsp_fire;
   int                 rsp_stall;

   field_point_camera_projection uut (.*);

   // Clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int reg_width(int idx);
      case (idx)
         REG_ROBOT_X, REG_ROBOT_Y, REG_FOCAL: reg_width = 12;
         REG_CAM_HEIGHT: reg_width = 8;
         default: reg_width = 17;
      endcase
   endfunction

   function automatic longint sext(longint v, int w);
      longint m;
      m = v & ((64'sd1 << w) - 1);
      if (m[w-1]) m = m - (64'sd1 << w);
      return m;
   endfunction

   function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
      return (a * b + (64'd1 << 29)) >> 30;
   endfunction

   // Quarter-wave sine, Taylor series by Horner in Q2.30, result Q1.15
   function automatic longint sine_quarter(longint unsigned f);
      longint unsigned dv[5];
      longint unsigned x, x2, t, s, q;
      dv = '{110, 72, 42, 20, 6};
      x  = f * 146409;
      x2 = mul_q30(x, x);
      t  = ONE_Q30;
      for (int i = 0; i < 5; i++) t = ONE_Q30 - mul_q30(x2, t) / dv[i];
      s = mul_q30(x, t);
      q = (s + (64'd1 << 14)) >> 15;
      if (q > 32767) q = 32767;
      return longint'(q);
   endfunction

   function automatic longint sine_deg(longint a);
      longint m, q, f, v;
      m = a % FULL_TURN;
      if (m < 0) m += FULL_TURN;
      q = m / QUARTER;
      f = m % QUARTER;
      v = q[0] ? sine_quarter(QUARTER - f) : sine_quarter(f);
      return (q >= 2) ? -v : v;
   endfunction

   function automatic longint round_shift(longint v, int n);
      return (v + (64'sd1 << (n - 1))) >>> n;
   endfunction

   function automatic longint add_centre(longint p, longint size);
      longint v;
      v = p + size / 2;
      if (size[0] && v < 0) v += 1;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   // Project one field point with the current pose
   function automatic pixel_type project_point(longint px_in, longint py_in, longint pz_in);
      pixel_type r;
      longint yaw, pit, tx, ty, tz, cy, sy, cp, sp, x1, y1, z1, y2, z2, foc, px, py;
      yaw = sext(pose_regs[REG_HEAD_YAW], 17) + sext(pose_regs[REG_ROBOT_HEADING], 17);
      pit = sext(pose_regs[REG_HEAD_PITCH], 17) + sext(pose_regs[REG_CAM_PITCH_OFS], 17);
      foc = pose_regs[REG_FOCAL];
      tx  = px_in - sext(pose_regs[REG_ROBOT_X], 12);
      ty  = py_in - sext(pose_regs[REG_ROBOT_Y], 12);
      tz  = pz_in - pose_regs[REG_CAM_HEIGHT];
      cy  = sine_deg(yaw + QUARTER);
      sy  = sine_deg(yaw);
      cp  = sine_deg(pit + QUARTER);
      sp  = sine_deg(pit);
      x1  = round_shift(cy * tx - sy * ty, 7);
      y1  = round_shift(sy * tx + cy * ty, 7);
      z1  = tz * 256;
      y2  = round_shift(cp * y1 - sp * z1, 15);
      z2  = round_shift(sp * y1 + cp * z1, 15);
      r.depth_zero = (z2 == 0);
      if (z2 == 0) begin
         px = -1;
         py = -1;
      end else begin
         px = (x1 * foc) / z2;
         py = (y2 * foc) / z2;
      end
      px = add_centre(px, IMAGE_W);
      py = add_centre(py, IMAGE_H);
      r.pixel_x  = 16'(px);
      r.pixel_y  = 16'(py);
      r.in_image = px >= 0 && px <= IMAGE_W && py >= 0 && py <= IMAGE_H;
      return r;
   endfunction

   function automatic int draw_gap();
      return no_gaps ? 0 : $urandom_range(0, 18);
   endfunction

   // Write one pose register; wait for the handshake
   task automatic write_reg(logic [3:0] idx, logic [16:0] data);
      bit fire;
      repeat (draw_gap() + 1) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do begin
         @(negedge clock);
         fire = csr_ready;
         @(posedge clock);
      end while (!fire);
      csr_valid <= 1'b0;
      if (idx < 8) pose_regs[idx] = data & ((64'sd1 << reg_width(idx)) - 1);
   endtask

   // Send one point word and queue its expected pixel; valid drops only on a gap
   task automatic send_point(logic signed [11:0] x, logic signed [11:0] y,
                             logic signed [11:0] z);
      int n;
      bit fire;
      n = draw_gap();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      do begin
         @(negedge clock);
         fire = req_ready;
         @(posedge clock);
      end while (!fire);
      pending_pixels.insert(pending_pixels.size(), project_point(x, y, z));
   endtask

   // Drop req valid, wait for every pixel to come back, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [16:0] pick_angle();
      case ($urandom_range(0, 5))
         0: return 17'(-46080);
         1: return 17'(46080);
         2: return 17'(11520);
         3: return 17'(-11520);
         4: return 17'(0);
         default: return 17'($urandom);
      endcase
   endfunction

   // Sample handshakes and check pixels between edges
   always @(negedge clock) begin
      rsp_fire = rsp_valid && rsp_ready && !reset;
      if ((req_valid && req_ready) || rsp_fire || (csr_valid && csr_ready) || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
      if (rsp_fire) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected rsp word");
            errors++;
         end else begin
            pixel_type e;
            e = pending_pixels.pop_front();
            if (rsp_pixel_x !== e.pixel_x) begin
               $error("pixel_x: expected %0d, got %0d", e.pixel_x, rsp_pixel_x);
               errors++;
            end
            if (rsp_pixel_y !== e.pixel_y) begin
               $error("pixel_y: expected %0d, got %0d", e.pixel_y, rsp_pixel_y);
               errors++;
            end
            if (rsp_in_image !== e.in_image) begin
               $error("in_image: expected %0d, got %0d", e.in_image, rsp_in_image);
               errors++;
            end
            if (rsp_depth_zero !== e.depth_zero) begin
               $error("depth_zero: expected %0d, got %0d", e.depth_zero, rsp_depth_zero);
               errors++;
            end
         end
      end
   end

   // Stall the rsp side for a random count after each word
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_fire) begin
         int n;
         n = draw_gap();
         rsp_ready <= (n == 0);
         rsp_stall <= n;
      end else if (!rsp_ready) begin
         if (rsp_stall <= 1) rsp_ready <= 1'b1;
         rsp_stall <= rsp_stall - 1;
      end
   end

   initial begin
      point_row_type rows[10];
      point_row_type row;
      logic signed [11:0] pz;

      errors      = 0;
      idle_cycles = 0;
      no_gaps     = 1'b0;
      rsp_fire    = 1'b0;
      for (int i = 0; i < 8; i++) pose_regs[i] = 0;
      pose_regs[REG_FOCAL] = 1;
      reset       <= 1'b1;
      csr_valid   <= 1'b0;
      csr_index   <= '0;
      csr_wdata   <= '0;
      req_valid   <= 1'b0;
      req_point_x <= '0;
      req_point_y <= '0;
      req_point_z <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed points at the reset pose; the origin sits at the camera
      rows = '{
         '{0, 0, 0, 1'b1, '{16'sd319, 16'sd239, 1'b1, 1'b1}},
         '{2047, 2047, 2047, 1'b0, '{0, 0, 0, 0}},
         '{-2048, -2048, -2048, 1'b0, '{0, 0, 0, 0}},
         '{2047, -2048, 1, 1'b0, '{0, 0, 0, 0}},
         '{-2048, 2047, -1, 1'b0, '{0, 0, 0, 0}},
         '{0, 0, 1, 1'b0, '{0, 0, 0, 0}},
         '{0, 0, -1, 1'b0, '{0, 0, 0, 0}},
         '{100, -50, 0, 1'b0, '{0, 0, 0, 0}},
         '{1, 1, 1, 1'b0, '{0, 0, 0, 0}},
         '{-1, -1, 2047, 1'b0, '{0, 0, 0, 0}}
      };
      foreach (rows[i]) begin
         row = rows[i];
         if (row.known && project_point(row.x, row.y, row.z) != row.pix) begin
            $error("predictor disagrees with directed row %0d", i);
            errors++;
         end
         send_point(row.x, row.y, row.z);
      end
      drain();

      // Directed pose: extremes, then a long focal length with a tilt
      write_reg(REG_FOCAL, 17'd4095);
      write_reg(REG_CAM_HEIGHT, 17'd255);
      write_reg(REG_HEAD_PITCH, 17'(46080));
      write_reg(REG_CAM_PITCH_OFS, 17'(-11520));
      write_reg(REG_ROBOT_HEADING, 17'(-46080));
      write_reg(REG_HEAD_YAW, 17'(5760));
      write_reg(REG_ROBOT_X, 17'(-2048));
      write_reg(REG_ROBOT_Y, 17'd2047);
      write_reg(4'd12, 17'h1ffff);
      for (int i = 0; i < 12; i++)
         send_point(12'($urandom), 12'($urandom), (i < 4) ? 12'sd255 : 12'($urandom));
      drain();

      // Random phases: new pose, then a batch of points
      for (int phase = 0; phase < 10; phase++) begin
         no_gaps = (phase % 4 == 3);
         for (int r = 0; r < 8; r++) begin
            case (r)
               REG_ROBOT_HEADING, REG_HEAD_YAW, REG_HEAD_PITCH, REG_CAM_PITCH_OFS:
                  write_reg(4'(r), (phase[0]) ? 17'($urandom) : pick_angle());
               REG_FOCAL:
                  write_reg(4'(r), ($urandom_range(0, 3) == 0) ?
                            17'($urandom_range(0, 1) * 4095) : 17'($urandom));
               default:
                  write_reg(4'(r), 17'($urandom));
            endcase
         end
         write_reg(4'($urandom_range(8, 15)), 17'($urandom));
         for (int i = 0; i < 155; i++) begin
            case ($urandom_range(0, 7))
               0: pz = 12'(pose_regs[REG_CAM_HEIGHT]);
               1: pz = 12'($urandom_range(0, 8)) - 12'sd4;
               default: pz = 12'($urandom);
            endcase
            if ($urandom_range(0, 1))
               send_point(12'($urandom), 12'($urandom), pz);
            else
               send_point(12'($urandom_range(0, 400)) - 12'sd200,
                          12'($urandom_range(0, 400)) - 12'sd200, pz);
         end
         drain();
      end

      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl/core
rtl/core/fpcp_pkg.sv
rtl/core/fpcp_trig.sv
rtl/core/fpcp_xform.sv
rtl/core/fpcp_div.sv
rtl/core/field_point_camera_projection.sv
test/tb.sv
